>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/prlf_pkg.sv
// ----------------------------------------------------------------------------
// prlf_pkg
// Widths, status codes and register indexes of the page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package prlf_pkg;

   localparam int ADDR_W       = 48;
   localparam int PAGE_OUT_W   = 36;
   localparam int TOTAL_W      = 32;
   localparam int STATUS_W     = 2;
   localparam int SLOTS_CFG_W  = 5;
   localparam int REGION_CFG_W = 19;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 36;

   localparam logic [STATUS_W-1:0] STATUS_HIT     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_PAGES = 2'd3;

   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   localparam logic [SLOTS_CFG_W-1:0]  SLOTS_CFG_RESET  = 5'd16;
   localparam logic [REGION_CFG_W-1:0] REGION_CFG_RESET = 19'd262144;

endpackage

`default_nettype wire

>>> hw/rtl/page_replacement_lru_fifo.sv
// An address outside the region goes from the check state straight to the response
// state; an in-region FIFO hit runs only the lookup pass, an LRU hit or any miss also
// the age update pass. One request is taken at a time, in the idle state only, and the
// slot table RAM is stepped one slot per cycle, once for each pass that is run.
// Reset (synchronous, active high) clears all slot valid bits, the resident count,
// both counters and the registers to LRU, 16 slots, base 0, 262144 pages.
// ----------------------------------------------------------------------------
// page_replacement_lru_fifo
// Fully associative resident-page set with LRU or FIFO replacement, one slot
// examined per cycle by a small sequencer around a slot table RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module page_replacement_lru_fifo #(
   parameter int SLOTS      = 16,
   parameter int PAGE_SHIFT = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [prlf_pkg::ADDR_W-1:0]          req_fault_address,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [prlf_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                      rsp_evicted_valid,
   output logic      [prlf_pkg::PAGE_OUT_W-1:0]      rsp_evicted_page,
   output logic      [prlf_pkg::TOTAL_W-1:0]         rsp_fault_total,
   output logic      [prlf_pkg::TOTAL_W-1:0]         rsp_eviction_total,
   input  wire logic                                 csr_wen,
   input  wire logic [prlf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [prlf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import prlf_pkg::*;

   localparam int PAGE_W = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RANK_W = IDX_W;
   localparam int LIM_W  = RANK_W + 1;
   localparam int SEQ_W  = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (PAGE_W > PAGE_OUT_W) ? PAGE_W : PAGE_OUT_W;
   localparam int ENTRY_W = PAGE_W + RANK_W;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CHECK   = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_DECIDE  = 6'b001000,
      ST_UPDATE  = 6'b010000,
      ST_RESPOND = 6'b100000
   } state_type;

   // control state
   state_type               state_ff, state_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]        data_idx_ff, data_idx_in;
   logic [SLOTS-1:0]        valid_ff, valid_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [TOTAL_W-1:0]      fault_cnt_ff, fault_cnt_in;
   logic [TOTAL_W-1:0]      evict_cnt_ff, evict_cnt_in;
   logic                    hit_found_ff, hit_found_in;
   logic                    vict_found_ff, vict_found_in;
   logic                    free_found_ff, free_found_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // configuration
   logic                    cfg_policy_ff, cfg_policy_in;
   logic [SLOTS_CFG_W-1:0]  cfg_slots_ff, cfg_slots_in;
   logic [PAGE_OUT_W-1:0]   cfg_base_ff, cfg_base_in;
   logic [REGION_CFG_W-1:0] cfg_pages_ff, cfg_pages_in;

   // working payload
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]       hit_rank_ff, hit_rank_in;
   logic [IDX_W-1:0]        vict_idx_ff, vict_idx_in;
   logic [RANK_W-1:0]       vict_rank_ff, vict_rank_in;
   logic [PAGE_W-1:0]       vict_page_ff, vict_page_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]        target_ff, target_in;
   logic [LIM_W-1:0]        lim_ff, lim_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    ev_valid_ff, ev_valid_in;
   logic [PAGE_OUT_W-1:0]   ev_page_ff, ev_page_in;

   // response register
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_OUT_W-1:0]   rsp_ev_page_ff, rsp_ev_page_in;
   logic [TOTAL_W-1:0]      rsp_fault_ff, rsp_fault_in;
   logic [TOTAL_W-1:0]      rsp_evict_ff, rsp_evict_in;

   // slot table RAM
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic                    ram_rd_en;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;
   logic [PAGE_W-1:0]       rd_page;
   logic [RANK_W-1:0]       rd_rank;

   // helpers
   logic [CMP_W-1:0]        page_cmp;
   logic [CMP_W-1:0]        base_cmp;
   logic [CMP_W-1:0]        region_off;
   logic                    in_region;
   logic [7:0]              slot_limit;
   logic                    evict_cond;

   prlf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_page = ram_rd_data[RANK_W +: PAGE_W];
   assign rd_rank = ram_rd_data[RANK_W-1:0];

   assign page_cmp   = CMP_W'(page_ff);
   assign base_cmp   = CMP_W'(cfg_base_ff);
   assign region_off = page_cmp - base_cmp;
   assign in_region  = (page_cmp >= base_cmp) && (region_off < CMP_W'(cfg_pages_ff));

   // clamp the slot limit into 1..SLOTS
   always_comb begin
      if (cfg_slots_ff == '0) begin
         slot_limit = 8'd1;
      end else if (8'(cfg_slots_ff) > 8'(SLOTS)) begin
         slot_limit = 8'(SLOTS);
      end else begin
         slot_limit = 8'(cfg_slots_ff);
      end
   end

   assign evict_cond = (8'(count_ff) >= slot_limit) && vict_found_ff;

   always_comb begin
      state_in        = state_ff;
      seq_in          = seq_ff;
      rd_pend_in      = 1'b0;
      data_idx_in     = data_idx_ff;
      valid_in        = valid_ff;
      count_in        = count_ff;
      fault_cnt_in    = fault_cnt_ff;
      evict_cnt_in    = evict_cnt_ff;
      hit_found_in    = hit_found_ff;
      vict_found_in   = vict_found_ff;
      free_found_in   = free_found_ff;
      rsp_valid_in    = rsp_valid_ff;
      cfg_policy_in   = cfg_policy_ff;
      cfg_slots_in    = cfg_slots_ff;
      cfg_base_in     = cfg_base_ff;
      cfg_pages_in    = cfg_pages_ff;
      page_in         = page_ff;
      hit_idx_in      = hit_idx_ff;
      hit_rank_in     = hit_rank_ff;
      vict_idx_in     = vict_idx_ff;
      vict_rank_in    = vict_rank_ff;
      vict_page_in    = vict_page_ff;
      free_idx_in     = free_idx_ff;
      target_in       = target_ff;
      lim_in          = lim_ff;
      status_in       = status_ff;
      ev_valid_in     = ev_valid_ff;
      ev_page_in      = ev_page_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_fault_in    = rsp_fault_ff;
      rsp_evict_in    = rsp_evict_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = data_idx_ff;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = seq_ff[IDX_W-1:0];

      if (csr_wen) begin
         unique case (csr_index)
            CSR_POLICY:       cfg_policy_in = csr_wdata[0];
            CSR_SLOTS_IN_USE: cfg_slots_in  = csr_wdata[SLOTS_CFG_W-1:0];
            CSR_REGION_BASE:  cfg_base_in   = csr_wdata[PAGE_OUT_W-1:0];
            CSR_REGION_PAGES: cfg_pages_in  = csr_wdata[REGION_CFG_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // lookup pass: examine the entry read in the previous cycle
      if (state_ff == ST_SCAN && rd_pend_ff) begin
         if (valid_ff[data_idx_ff]) begin
            if (!hit_found_ff && rd_page == page_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = data_idx_ff;
               hit_rank_in  = rd_rank;
            end
            if (!vict_found_ff || rd_rank > vict_rank_ff) begin
               vict_found_in = 1'b1;
               vict_idx_in   = data_idx_ff;
               vict_rank_in  = rd_rank;
               vict_page_in  = rd_page;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = data_idx_ff;
         end
      end

      // age update pass: target becomes age zero, younger valid slots age by one
      if (state_ff == ST_UPDATE && rd_pend_ff) begin
         if (data_idx_ff == target_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {page_ff, RANK_W'(0)};
         end else if (valid_ff[data_idx_ff] && LIM_W'(rd_rank) < lim_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {rd_page, rd_rank + RANK_W'(1)};
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in  = req_fault_address[ADDR_W-1 -: PAGE_W];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            seq_in        = '0;
            hit_found_in  = 1'b0;
            vict_found_in = 1'b0;
            free_found_in = 1'b0;
            ev_valid_in   = 1'b0;
            ev_page_in    = '0;
            if (in_region) begin
               if (fault_cnt_ff != '1) begin
                  fault_cnt_in = fault_cnt_ff + TOTAL_W'(1);
               end
               state_in = ST_SCAN;
            end else begin
               status_in = STATUS_OUTSIDE;
               state_in  = ST_RESPOND;
            end
         end
         ST_SCAN, ST_UPDATE: begin
            if (seq_ff != SEQ_W'(SLOTS)) begin
               ram_rd_en   = 1'b1;
               rd_pend_in  = 1'b1;
               data_idx_in = seq_ff[IDX_W-1:0];
               seq_in      = seq_ff + SEQ_W'(1);
            end else if (state_ff == ST_SCAN) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_DECIDE: begin
            seq_in = '0;
            if (hit_found_ff) begin
               status_in = STATUS_HIT;
               target_in = hit_idx_ff;
               lim_in    = LIM_W'(hit_rank_ff);
               state_in  = (cfg_policy_ff == POLICY_LRU) ? ST_UPDATE : ST_RESPOND;
            end else begin
               status_in = STATUS_MISS;
               lim_in    = LIM_W'(SLOTS);
               state_in  = ST_UPDATE;
               if (evict_cond) begin
                  // the victim slot is reused, so the resident count holds
                  ev_valid_in = 1'b1;
                  ev_page_in  = PAGE_OUT_W'(vict_page_ff);
                  target_in   = vict_idx_ff;
                  if (evict_cnt_ff != '1) begin
                     evict_cnt_in = evict_cnt_ff + TOTAL_W'(1);
                  end
               end else begin
                  target_in             = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + CNT_W'(1);
               end
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_ev_valid_in = ev_valid_ff;
               rsp_ev_page_in  = ev_page_ff;
               rsp_fault_in    = fault_cnt_ff;
               rsp_evict_in    = evict_cnt_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seq_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         fault_cnt_ff  <= '0;
         evict_cnt_ff  <= '0;
         hit_found_ff  <= 1'b0;
         vict_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cfg_policy_ff <= POLICY_LRU;
         cfg_slots_ff  <= SLOTS_CFG_RESET;
         cfg_base_ff   <= '0;
         cfg_pages_ff  <= REGION_CFG_RESET;
      end else begin
         state_ff      <= state_in;
         seq_ff        <= seq_in;
         rd_pend_ff    <= rd_pend_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         fault_cnt_ff  <= fault_cnt_in;
         evict_cnt_ff  <= evict_cnt_in;
         hit_found_ff  <= hit_found_in;
         vict_found_ff <= vict_found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_policy_ff <= cfg_policy_in;
         cfg_slots_ff  <= cfg_slots_in;
         cfg_base_ff   <= cfg_base_in;
         cfg_pages_ff  <= cfg_pages_in;
      end
   end

   always_ff @(posedge clock) begin
      data_idx_ff     <= data_idx_in;
      page_ff         <= page_in;
      hit_idx_ff      <= hit_idx_in;
      hit_rank_ff     <= hit_rank_in;
      vict_idx_ff     <= vict_idx_in;
      vict_rank_ff    <= vict_rank_in;
      vict_page_ff    <= vict_page_in;
      free_idx_ff     <= free_idx_in;
      target_ff       <= target_in;
      lim_ff          <= lim_in;
      status_ff       <= status_in;
      ev_valid_ff     <= ev_valid_in;
      ev_page_ff      <= ev_page_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_fault_ff    <= rsp_fault_in;
      rsp_evict_ff    <= rsp_evict_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_evicted_valid  = rsp_ev_valid_ff;
   assign rsp_evicted_page   = rsp_ev_page_ff;
   assign rsp_fault_total    = rsp_fault_ff;
   assign rsp_eviction_total = rsp_evict_ff;

   `ASSERT_IMPLY(a_count_tracks_valid, clock, reset, 1'b1, CNT_W'($countones(valid_ff)) == count_ff, "resident count differs from valid slots")
   `ASSERT_IMPLY(a_free_slot_on_insert, clock, reset, state_ff == ST_DECIDE && !hit_found_ff && !evict_cond, free_found_ff, "insert without eviction found no free slot")
   `ASSERT_NEXT(a_evict_counts, clock, reset, state_ff == ST_DECIDE && !hit_found_ff && evict_cond && evict_cnt_ff != '1, evict_cnt_ff == $past(evict_cnt_ff) + TOTAL_W'(1), "eviction not counted")
   `ASSERT_IMPLY(a_update_write_in_range, clock, reset, ram_wr_en, state_ff == ST_UPDATE, "slot table written outside the update pass")

endmodule

`default_nettype wire

>>> hw/rtl/prlf_ram.sv
// ----------------------------------------------------------------------------
// prlf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module prlf_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> bench/tb_page_replacement_lru_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_replacement_lru_fifo
// Self-checking bench for the LRU/FIFO page replacement block. A driver and a
// monitor run on the clock; an internal predictor of the resident-page set
// forms the expected response of every accepted fault address, and each
// response is checked field by field. Directed accesses cover the corners,
// then randomized phases with varied registers and handshake pressure follow.
// ----------------------------------------------------------------------------
module tb_page_replacement_lru_fifo;
   import prlf_pkg::*;

   localparam int SLOTS          = 16;
   localparam int PAGE_SHIFT     = 12;
   localparam int AGE_W          = $clog2(SLOTS);
   localparam int DRAIN_CYCLES   = 2 * SLOTS + 5;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 100;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  evicted_valid;
      logic [PAGE_OUT_W-1:0] evicted_page;
      logic [TOTAL_W-1:0]    fault_total;
      logic [TOTAL_W-1:0]    eviction_total;
   } fault_outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [ADDR_W-1:0]       req_fault_address = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_evicted_valid;
   logic [PAGE_OUT_W-1:0]   rsp_evicted_page;
   logic [TOTAL_W-1:0]      rsp_fault_total;
   logic [TOTAL_W-1:0]      rsp_eviction_total;
   logic                    csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_POLICY;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Predictor copy of the registers
   logic                    cfg_policy = POLICY_LRU;
   logic [SLOTS_CFG_W-1:0]  cfg_slots = SLOTS_CFG_RESET;
   logic [PAGE_OUT_W-1:0]   cfg_base = '0;
   logic [REGION_CFG_W-1:0] cfg_region_pages = REGION_CFG_RESET;

   // Predictor copy of the resident set
   logic [PAGE_OUT_W-1:0]   slot_page [SLOTS];
   bit                      slot_live [SLOTS];
   bit   [AGE_W-1:0]        slot_age [SLOTS];
   int                      resident_count = 0;
   logic [TOTAL_W-1:0]      fault_count = '0;
   logic [TOTAL_W-1:0]      eviction_count = '0;

   logic [ADDR_W-1:0]       fault_addresses_to_send [$];
   fault_outcome_type       expected_outcomes [$];
   logic [PAGE_OUT_W-1:0]   working_pages [$];
   int                      sender_idle_pct = 0;
   int                      receiver_stall_pct = 0;
   int                      mismatch_count = 0;
   int                      quiet_cycles = 0;

   page_replacement_lru_fifo #(
      .SLOTS      (SLOTS),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_fault_address  (req_fault_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_total    (rsp_fault_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   // Make slot s the youngest; valid slots younger than limit_age grow one older.
   function automatic void make_youngest(input int s, input int limit_age);
      int i;
      for (i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && i != s && slot_age[i] < limit_age) begin
            slot_age[i]++;
         end
      end
      slot_age[s] = '0;
   endfunction

   function automatic void predict_fault_outcome(input logic [ADDR_W-1:0] address);
      logic [PAGE_OUT_W-1:0] page;
      fault_outcome_type     outcome;
      int                    hit_slot;
      int                    victim;
      int                    limit;
      int                    i;
      page     = address[ADDR_W-1:PAGE_SHIFT];
      outcome  = '0;
      hit_slot = -1;
      victim   = -1;
      if (page < cfg_base || (page - cfg_base) >= cfg_region_pages) begin
         outcome.status = STATUS_OUTSIDE;
      end else begin
         if (fault_count != '1) fault_count++;
         for (i = 0; i < SLOTS; i++) begin
            if (hit_slot < 0 && slot_live[i] && slot_page[i] == page) hit_slot = i;
         end
         if (hit_slot >= 0) begin
            outcome.status = STATUS_HIT;
            if (cfg_policy == POLICY_LRU) make_youngest(hit_slot, slot_age[hit_slot]);
         end else begin
            outcome.status = STATUS_MISS;
            limit = cfg_slots;
            if (limit == 0) limit = 1;
            if (limit > SLOTS) limit = SLOTS;
            if (resident_count >= limit) begin
               for (i = 0; i < SLOTS; i++) begin
                  if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
               end
               if (victim >= 0) begin
                  outcome.evicted_valid = 1'b1;
                  outcome.evicted_page  = slot_page[victim];
                  slot_live[victim]     = 1'b0;
                  resident_count--;
                  if (eviction_count != '1) eviction_count++;
               end
            end
            for (i = 0; i < SLOTS; i++) begin
               if (victim < 0 && !slot_live[i]) victim = i;
            end
            if (victim >= 0) begin
               slot_page[victim] = page;
               slot_live[victim] = 1'b1;
               resident_count++;
               make_youngest(victim, SLOTS);
            end
         end
      end
      outcome.fault_total    = fault_count;
      outcome.eviction_total = eviction_count;
      expected_outcomes.push_back(outcome);
   endfunction

   function automatic void compare_field(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Pages of the region that are reachable above the base without wrapping
   function automatic logic [36:0] region_span();
      logic [36:0] room;
      room = 37'h10_0000_0000 - cfg_base;
      return (cfg_region_pages < room) ? 37'(cfg_region_pages) : room;
   endfunction

   function automatic logic [PAGE_OUT_W-1:0] page_in_region();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return cfg_base + PAGE_OUT_W'(r % region_span());
   endfunction

   function automatic logic [ADDR_W-1:0] random_fault_address();
      logic [PAGE_OUT_W-1:0] page;
      int                    pick;
      pick = $urandom_range(99);
      if (region_span() == 0 || pick >= 90) return ADDR_W'({$urandom(), $urandom()});
      if (pick < 72) page = working_pages[$urandom_range(working_pages.size() - 1)];
      else if (pick < 82) page = page_in_region();
      else if (pick < 86) page = cfg_base - 1'b1;
      else page = cfg_base + PAGE_OUT_W'(region_span());
      return {page, PAGE_SHIFT'($urandom())};
   endfunction

   function automatic bit block_idle();
      return fault_addresses_to_send.size() == 0 && !req_valid && expected_outcomes.size() == 0;
   endfunction

   task automatic wait_for_idle();
      while (!block_idle()) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Hold until idle, write every register, set the pressure and fill the page pool.
   task automatic start_phase(input logic policy, input logic [SLOTS_CFG_W-1:0] slots,
                              input logic [PAGE_OUT_W-1:0] base,
                              input logic [REGION_CFG_W-1:0] pages, input int pressure);
      int i;
      int pool_size;
      wait_for_idle();
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_POLICY;
      csr_wdata <= CSR_DATA_W'(policy);
      @(posedge clock);
      csr_index <= CSR_SLOTS_IN_USE;
      csr_wdata <= CSR_DATA_W'(slots);
      @(posedge clock);
      csr_index <= CSR_REGION_BASE;
      csr_wdata <= CSR_DATA_W'(base);
      @(posedge clock);
      csr_index <= CSR_REGION_PAGES;
      csr_wdata <= CSR_DATA_W'(pages);
      @(posedge clock);
      csr_wen          <= 1'b0;
      cfg_policy       = policy;
      cfg_slots        = slots;
      cfg_base         = base;
      cfg_region_pages = pages;
      case (pressure % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
         default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
      endcase
      // pool of the slot limit plus up to eight pages gives both hits and evictions
      working_pages.delete();
      if (region_span() != 0) begin
         pool_size = (slots == 0 ? 1 : (slots > SLOTS ? SLOTS : slots)) + $urandom_range(8);
         for (i = 0; i < pool_size; i++) working_pages.push_back(page_in_region());
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (fault_addresses_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid         <= 1'b1;
            req_fault_address <= fault_addresses_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t ns: unexpected response: expected none, actual status %0d",
                        $time, rsp_status);
               mismatch_count++;
            end else begin
               compare_field("status", expected_outcomes[0].status, rsp_status);
               compare_field("evicted_valid", expected_outcomes[0].evicted_valid,
                             rsp_evicted_valid);
               compare_field("evicted_page", expected_outcomes[0].evicted_page,
                             rsp_evicted_page);
               compare_field("fault_total", expected_outcomes[0].fault_total,
                             rsp_fault_total);
               compare_field("eviction_total", expected_outcomes[0].eviction_total,
                             rsp_eviction_total);
               void'(expected_outcomes.pop_front());
            end
         end
         if (req_valid && req_ready) predict_fault_outcome(req_fault_address);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int                      phase;
      int                      n;
      logic                    policy;
      logic [SLOTS_CFG_W-1:0]  slots;
      logic [PAGE_OUT_W-1:0]   base;
      logic [REGION_CFG_W-1:0] pages;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset registers: region edges, the top address, LRU hits
      fault_addresses_to_send.push_back({36'd0, 12'h000});
      fault_addresses_to_send.push_back({36'd262143, 12'hFFF});
      fault_addresses_to_send.push_back({36'd262144, 12'h000});
      fault_addresses_to_send.push_back(48'hFFFF_FFFF_FFFF);
      fault_addresses_to_send.push_back({36'd0, 12'h7FF});
      fault_addresses_to_send.push_back({36'd1, 12'h001});
      fault_addresses_to_send.push_back({36'd0, 12'h000});

      // slot limit zero below the resident count, FIFO misses with evictions
      start_phase(POLICY_FIFO, 5'd0, 36'd0, REGION_CFG_RESET, 0);
      fault_addresses_to_send.push_back({36'd5, 12'h000});
      fault_addresses_to_send.push_back({36'd262143, 12'h123});
      fault_addresses_to_send.push_back({36'd6, 12'hABC});

      // policy switch with pages resident, limit above the slot count, region past the top
      start_phase(POLICY_LRU, 5'd31, 36'hF_FFFF_FFFC, REGION_CFG_RESET, 0);
      fault_addresses_to_send.push_back({36'hF_FFFF_FFFC, 12'h000});
      fault_addresses_to_send.push_back(48'hFFFF_FFFF_FFFF);
      fault_addresses_to_send.push_back({36'hF_FFFF_FFFB, 12'hFFF});
      fault_addresses_to_send.push_back({36'hF_FFFF_FFFF, 12'h000});

      // empty region
      start_phase(POLICY_LRU, 5'd16, 36'd0, 19'd0, 0);
      fault_addresses_to_send.push_back({36'd0, 12'h000});

      start_phase(POLICY_LRU, 5'd1, 36'd0, 19'h7FFFF, 0);
      fault_addresses_to_send.push_back({36'd524286, 12'h555});

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: start_phase(POLICY_LRU, SLOTS_CFG_RESET, '0, REGION_CFG_RESET, phase);
            1: start_phase(POLICY_FIFO, 5'd1, '1, 19'd1, phase);
            default: begin
               policy = $urandom_range(1) ? POLICY_FIFO : POLICY_LRU;
               slots  = ($urandom_range(3) == 0) ? SLOTS_CFG_W'($urandom_range(31))
                                                 : SLOTS_CFG_W'($urandom_range(SLOTS, 1));
               case ($urandom_range(2))
                  0: base = '0;
                  1: base = '1 - PAGE_OUT_W'($urandom_range(600000));
                  default: base = PAGE_OUT_W'({$urandom(), $urandom()});
               endcase
               case ($urandom_range(3))
                  0: pages = REGION_CFG_W'($urandom_range(64, 1));
                  1: pages = REGION_CFG_RESET;
                  2: pages = '1;
                  default: pages = REGION_CFG_W'($urandom());
               endcase
               start_phase(policy, slots, base, pages, phase);
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) fault_addresses_to_send.push_back(random_fault_address());
      end

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
